// ----- design/hre_pkg.sv -----
// Shared types, constants and command codes for the homography reprojection error block.
package hre_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd5;

	localparam logic [31:0] TOL_RESET = 32'd18446744;

	localparam logic [1:0] PT_OK    = 2'd0;
	localparam logic [1:0] PT_SMALL = 2'd1;
	localparam logic [1:0] PT_SAT   = 2'd2;

	localparam int ITER_STEP_W = 7;

	typedef enum logic [5:0] {
		STEP_IDLE,
		STEP_P0, STEP_P1, STEP_P2, STEP_P3, STEP_P4, STEP_P5,
		STEP_P6, STEP_P7, STEP_P8, STEP_P9, STEP_P10, STEP_P11,
		STEP_W_RA, STEP_RP_S, STEP_W_RP,
		STEP_M0, STEP_M1, STEP_M2, STEP_M3, STEP_CHK,
		STEP_DX_S, STEP_DX_W, STEP_DY_S, STEP_DY_W,
		STEP_E0, STEP_E1, STEP_E2, STEP_E3,
		STEP_SQ_S, STEP_SQ_W, STEP_ACC, STEP_FIN,
		STEP_R_S, STEP_R_W, STEP_RS_S, STEP_RS_W,
		STEP_PUSH
	} step_t;

	typedef struct packed {
		step_t step;
		logic  ready;
	} cmd_t;

	typedef struct packed {
		logic iter_busy;
		logic too_small;
		logic last;
	} stat_t;

	typedef struct packed {
		logic [31:0] h00;
		logic [31:0] h01;
		logic [31:0] h02;
		logic [31:0] h10;
		logic [31:0] h11;
		logic [31:0] h12;
		logic [31:0] h20;
		logic [31:0] h21;
		logic [31:0] h22;
		logic [31:0] tol;
	} coef_t;

	typedef struct packed {
		logic [31:0] mapped_x;
		logic [31:0] mapped_y;
		logic [31:0] error_dist;
		logic [1:0]  point_status;
		logic [31:0] rms_error;
		logic        rms_valid;
		logic        set_end;
	} res_t;

	typedef struct packed {
		logic                   start;
		logic                   sqrt_mode;
		logic [ITER_STEP_W-1:0] steps;
	} iter_cmd_t;

endpackage

// ----- design/hre_iter.sv -----
// Shared iterative unit: restoring divider (one quotient bit a cycle) and integer square root.
module hre_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  hre_pkg::iter_cmd_t icmd,
	input  logic [63:0]        rem_init,
	input  logic [63:0]        dvd_init,
	input  logic [63:0]        divisor,
	output logic               busy,
	output logic [63:0]        quo,
	output logic [63:0]        rem
);

	logic [hre_pkg::ITER_STEP_W-1:0] cnt_q;
	logic        sqrt_q;
	logic [63:0] rem_q, dvd_q, dsr_q, quo_q;
	logic [64:0] dtry;
	logic [64:0] ddiff;
	logic [63:0] stry, trial, sdiff;

	always_comb begin
		dtry  = {rem_q, dvd_q[63]};
		ddiff = dtry - {1'b0, dsr_q};
		stry  = {rem_q[61:0], dvd_q[63:62]};
		trial = {30'd0, quo_q[31:0], 2'b01};
		sdiff = stry - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (icmd.start) begin
			cnt_q <= icmd.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (icmd.start) begin
			sqrt_q <= icmd.sqrt_mode;
			rem_q  <= rem_init;
			dvd_q  <= dvd_init;
			dsr_q  <= divisor;
			quo_q  <= '0;
		end else if (cnt_q != '0) begin
			if (sqrt_q) begin
				dvd_q <= {dvd_q[61:0], 2'b00};
				if (stry >= trial) begin
					rem_q <= sdiff;
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= stry;
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end else begin
				dvd_q <= {dvd_q[62:0], 1'b0};
				if (dtry >= {1'b0, dsr_q}) begin
					rem_q <= ddiff[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= dtry[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- design/hre_dp.sv -----
// Datapath: shared multiplier, accumulator, divide/root unit and per-set accumulation state.
module hre_dp #(
	parameter int FRAC_BITS  = hre_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = hre_pkg::COUNT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_take,
	input  logic [31:0]    src_x,
	input  logic [31:0]    src_y,
	input  logic [31:0]    dst_x,
	input  logic [31:0]    dst_y,
	input  logic           set_last,
	input  hre_pkg::coef_t coef,
	input  hre_pkg::cmd_t  cmd,
	output hre_pkg::stat_t stat,
	output hre_pkg::res_t  res
);

	localparam logic [hre_pkg::ITER_STEP_W-1:0] DIV_STEPS =
		hre_pkg::ITER_STEP_W'(33 + FRAC_BITS);
	localparam logic [hre_pkg::ITER_STEP_W-1:0] RMS_STEPS  = hre_pkg::ITER_STEP_W'(64);
	localparam logic [hre_pkg::ITER_STEP_W-1:0] ROOT_STEPS = hre_pkg::ITER_STEP_W'(32);
	localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	function automatic logic [63:0] fl4(input logic [63:0] p);
		fl4 = {{2{p[63]}}, p[63:2]};
	endfunction

	function automatic logic [63:0] shc(input logic [31:0] h);
		shc = {{32{h[31]}}, h} << (FRAC_BITS - 2);
	endfunction

	function automatic logic [63:0] mag64(input logic [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [32:0] sx(input logic [31:0] v);
		sx = {v[31], v};
	endfunction

	function automatic logic [32:0] zx(input logic [31:0] v);
		zx = {1'b0, v};
	endfunction

	logic [31:0] x_q, y_q, dx_q, dy_q;
	logic        last_q;
	logic [63:0] prod_q, acc_q, w_q, xn_q, yn_q, wabs_q, lo_q;
	logic        wneg_q, too_small_q, ovf_q, nneg_q, sat_q;
	logic [31:0] ra_q, rp_q, mhi_q, mx_q, my_q, ax_q, ay_q, dist_q;
	logic [64:0] sq_q;
	logic [63:0] sqv_q;
	logic [1:0]  status_q;
	logic [31:0] rms_q;
	logic        rmsv_q;
	logic [63:0]           sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  failed_q;

	logic [32:0]         mul_a, mul_b;
	logic signed [65:0]  mul_full;
	hre_pkg::iter_cmd_t  icmd;
	logic [63:0]         it_rem_in, it_dvd_in, it_dsr_in, it_quo, it_rem;
	logic                it_busy;
	logic [63:0]         un_sel, qr, lim, thr;
	logic                fsat;
	logic [31:0]         qv, fres;
	logic [32:0]         rnd, dxd, dyd;
	logic [64:0]         sum_add;
	logic [1:0]          status_d;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			hre_pkg::STEP_P0:  begin mul_a = sx(coef.h20); mul_b = sx(x_q); end
			hre_pkg::STEP_P1:  begin mul_a = sx(coef.h21); mul_b = sx(y_q); end
			hre_pkg::STEP_P2:  begin mul_a = sx(coef.h00); mul_b = sx(x_q); end
			hre_pkg::STEP_P3:  begin mul_a = sx(coef.h01); mul_b = sx(y_q); end
			hre_pkg::STEP_P4:  begin mul_a = sx(coef.h10); mul_b = sx(x_q); end
			hre_pkg::STEP_P5:  begin mul_a = sx(coef.h11); mul_b = sx(y_q); end
			hre_pkg::STEP_P6:  begin mul_a = sx(coef.h20); mul_b = sx(coef.h20); end
			hre_pkg::STEP_P7:  begin mul_a = sx(coef.h21); mul_b = sx(coef.h21); end
			hre_pkg::STEP_P8:  begin mul_a = sx(coef.h22); mul_b = sx(coef.h22); end
			hre_pkg::STEP_P9:  begin mul_a = sx(x_q); mul_b = sx(x_q); end
			hre_pkg::STEP_P10: begin mul_a = sx(y_q); mul_b = sx(y_q); end
			hre_pkg::STEP_M0:  begin mul_a = zx(ra_q); mul_b = zx(rp_q); end
			hre_pkg::STEP_M1:  begin mul_a = zx(coef.tol); mul_b = zx(prod_q[31:0]); end
			hre_pkg::STEP_M2:  begin mul_a = zx(coef.tol); mul_b = zx(mhi_q); end
			hre_pkg::STEP_E1:  begin mul_a = zx(ax_q); mul_b = zx(ax_q); end
			hre_pkg::STEP_E2:  begin mul_a = zx(ay_q); mul_b = zx(ay_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_full = $signed(mul_a) * $signed(mul_b);

	// divide / root unit operand select
	always_comb begin
		un_sel    = mag64((cmd.step == hre_pkg::STEP_DY_S) ? yn_q : xn_q);
		icmd      = '0;
		it_rem_in = '0;
		it_dvd_in = '0;
		it_dsr_in = '0;
		case (cmd.step)
			hre_pkg::STEP_P10, hre_pkg::STEP_RP_S: begin
				icmd      = '{start: 1'b1, sqrt_mode: 1'b1, steps: ROOT_STEPS};
				it_dvd_in = acc_q;
			end
			hre_pkg::STEP_SQ_S: begin
				icmd      = '{start: 1'b1, sqrt_mode: 1'b1, steps: ROOT_STEPS};
				it_dvd_in = sq_q[63:0];
			end
			hre_pkg::STEP_RS_S: begin
				icmd      = '{start: 1'b1, sqrt_mode: 1'b1, steps: ROOT_STEPS};
				it_dvd_in = it_quo;
			end
			hre_pkg::STEP_DX_S, hre_pkg::STEP_DY_S: begin
				icmd      = '{start: 1'b1, sqrt_mode: 1'b0, steps: DIV_STEPS};
				it_rem_in = {32'd0, un_sel[63:32]};
				it_dvd_in = {un_sel[31:0], 32'd0};
				it_dsr_in = wabs_q;
			end
			hre_pkg::STEP_R_S: begin
				icmd      = '{start: 1'b1, sqrt_mode: 1'b0, steps: RMS_STEPS};
				it_dvd_in = sum_q;
				it_dsr_in = 64'(count_q);
			end
			default: icmd = '0;
		endcase
	end

	hre_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.icmd     (icmd),
		.rem_init (it_rem_in),
		.dvd_init (it_dvd_in),
		.divisor  (it_dsr_in),
		.busy     (it_busy),
		.quo      (it_quo),
		.rem      (it_rem)
	);

	// quotient rounding, clamping and sign; root rounding; difference terms; threshold, sum and status
	always_comb begin
		qr      = (it_quo + 64'd1) >> 1;
		lim     = nneg_q ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
		fsat    = ovf_q | (qr > lim);
		qv      = fsat ? lim[31:0] : qr[31:0];
		fres    = nneg_q ? (32'd0 - qv) : qv;
		rnd     = {1'b0, it_quo[31:0]} + 33'(it_rem > {32'd0, it_quo[31:0]});
		dxd     = sx(mx_q) - sx(dx_q);
		dyd     = sx(my_q) - sx(dy_q);
		thr     = (prod_q + {32'd0, lo_q[63:32]}) >> 34;
		sum_add = {1'b0, sum_q} + {1'b0, sqv_q};
		if (too_small_q) begin
			status_d = hre_pkg::PT_SMALL;
		end else if (sat_q) begin
			status_d = hre_pkg::PT_SAT;
		end else begin
			status_d = hre_pkg::PT_OK;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_full[63:0];
		if (in_take) begin
			x_q    <= src_x;
			y_q    <= src_y;
			dx_q   <= dst_x;
			dy_q   <= dst_y;
			last_q <= set_last;
			mx_q   <= '0;
			my_q   <= '0;
			dist_q <= '0;
			sat_q  <= 1'b0;
		end
		case (cmd.step)
			hre_pkg::STEP_P1: acc_q <= fl4(prod_q) + shc(coef.h22);
			hre_pkg::STEP_P2: begin
				w_q   <= acc_q + fl4(prod_q);
				acc_q <= shc(coef.h02);
			end
			hre_pkg::STEP_P3: begin
				acc_q  <= acc_q + fl4(prod_q);
				wabs_q <= mag64(w_q);
				wneg_q <= w_q[63];
			end
			hre_pkg::STEP_P4: begin
				xn_q  <= acc_q + fl4(prod_q);
				acc_q <= shc(coef.h12);
			end
			hre_pkg::STEP_P5: acc_q <= acc_q + fl4(prod_q);
			hre_pkg::STEP_P6: begin
				yn_q  <= acc_q + fl4(prod_q);
				acc_q <= '0;
			end
			hre_pkg::STEP_P7, hre_pkg::STEP_P8, hre_pkg::STEP_P9, hre_pkg::STEP_P11:
				acc_q <= acc_q + prod_q;
			hre_pkg::STEP_P10: acc_q <= ONE_SQ + prod_q;
			hre_pkg::STEP_W_RA: if (!it_busy) ra_q <= it_quo[31:0];
			hre_pkg::STEP_W_RP: if (!it_busy) rp_q <= it_quo[31:0];
			hre_pkg::STEP_M1: mhi_q <= prod_q[63:32];
			hre_pkg::STEP_M2: lo_q <= prod_q;
			hre_pkg::STEP_M3: too_small_q <= (wabs_q <= thr);
			hre_pkg::STEP_DX_S, hre_pkg::STEP_DY_S: begin
				ovf_q  <= ({32'd0, un_sel[63:32]} >= wabs_q);
				nneg_q <= ((cmd.step == hre_pkg::STEP_DY_S) ? yn_q[63] : xn_q[63]) ^ wneg_q;
			end
			hre_pkg::STEP_DX_W: if (!it_busy) begin
				mx_q  <= fres;
				sat_q <= sat_q | fsat;
			end
			hre_pkg::STEP_DY_W: if (!it_busy) begin
				my_q  <= fres;
				sat_q <= sat_q | fsat;
			end
			hre_pkg::STEP_E0: begin
				ax_q <= dxd[32] ? 32'(33'd0 - dxd) : dxd[31:0];
				ay_q <= dyd[32] ? 32'(33'd0 - dyd) : dyd[31:0];
			end
			hre_pkg::STEP_E2: acc_q <= prod_q;
			hre_pkg::STEP_E3: sq_q <= {1'b0, acc_q} + {1'b0, prod_q};
			hre_pkg::STEP_SQ_W: if (!it_busy) begin
				if (sq_q[64]) begin
					dist_q <= 32'hFFFF_FFFF;
					sqv_q  <= 64'hFFFF_FFFF_FFFF_FFFF;
					sat_q  <= 1'b1;
				end else begin
					sqv_q <= sq_q[63:0];
					if (rnd[32]) begin
						dist_q <= 32'hFFFF_FFFF;
						sat_q  <= 1'b1;
					end else begin
						dist_q <= rnd[31:0];
					end
				end
			end
			hre_pkg::STEP_FIN: begin
				status_q <= status_d;
				rms_q    <= '0;
				rmsv_q   <= 1'b0;
			end
			hre_pkg::STEP_RS_W: if (!it_busy) begin
				rms_q  <= rnd[32] ? 32'hFFFF_FFFF : rnd[31:0];
				rmsv_q <= !failed_q;
			end
			default: ;
		endcase
	end

	// set accumulation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			failed_q <= 1'b0;
		end else begin
			case (cmd.step)
				hre_pkg::STEP_ACC: sum_q <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
				hre_pkg::STEP_FIN: begin
					failed_q <= failed_q | (status_d != hre_pkg::PT_OK);
					if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
				end
				hre_pkg::STEP_RS_W: if (!it_busy) begin
					sum_q    <= '0;
					count_q  <= '0;
					failed_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign stat = '{iter_busy: it_busy, too_small: too_small_q, last: last_q};
	assign res  = '{mapped_x: mx_q, mapped_y: my_q, error_dist: dist_q,
		point_status: status_q, rms_error: rms_q, rms_valid: rmsv_q, set_end: last_q};

endmodule

// ----- design/hre_ctrl.sv -----
// Controller: sequences one item through the datapath steps.
module hre_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_take,
	input  logic           out_free,
	input  hre_pkg::stat_t stat,
	output hre_pkg::cmd_t  cmd
);

	// members follow the order of hre_pkg::step_t
	typedef enum logic [5:0] {
		S_IDLE,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5,
		S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
		S_W_RA, S_RP_S, S_W_RP,
		S_M0, S_M1, S_M2, S_M3, S_CHK,
		S_DX_S, S_DX_W, S_DY_S, S_DY_W,
		S_E0, S_E1, S_E2, S_E3,
		S_SQ_S, S_SQ_W, S_ACC, S_FIN,
		S_R_S, S_R_W, S_RS_S, S_RS_W,
		S_PUSH
	} state_t;

	state_t        state_q, state_d;
	hre_pkg::cmd_t cmd_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_take) state_d = S_P0;
			S_P0:    state_d = S_P1;
			S_P1:    state_d = S_P2;
			S_P2:    state_d = S_P3;
			S_P3:    state_d = S_P4;
			S_P4:    state_d = S_P5;
			S_P5:    state_d = S_P6;
			S_P6:    state_d = S_P7;
			S_P7:    state_d = S_P8;
			S_P8:    state_d = S_P9;
			S_P9:    state_d = S_P10;
			S_P10:   state_d = S_P11;
			S_P11:   state_d = S_W_RA;
			S_W_RA:  if (!stat.iter_busy) state_d = S_RP_S;
			S_RP_S:  state_d = S_W_RP;
			S_W_RP:  if (!stat.iter_busy) state_d = S_M0;
			S_M0:    state_d = S_M1;
			S_M1:    state_d = S_M2;
			S_M2:    state_d = S_M3;
			S_M3:    state_d = S_CHK;
			S_CHK:   state_d = stat.too_small ? S_FIN : S_DX_S;
			S_DX_S:  state_d = S_DX_W;
			S_DX_W:  if (!stat.iter_busy) state_d = S_DY_S;
			S_DY_S:  state_d = S_DY_W;
			S_DY_W:  if (!stat.iter_busy) state_d = S_E0;
			S_E0:    state_d = S_E1;
			S_E1:    state_d = S_E2;
			S_E2:    state_d = S_E3;
			S_E3:    state_d = S_SQ_S;
			S_SQ_S:  state_d = S_SQ_W;
			S_SQ_W:  if (!stat.iter_busy) state_d = S_ACC;
			S_ACC:   state_d = S_FIN;
			S_FIN:   state_d = stat.last ? S_R_S : S_PUSH;
			S_R_S:   state_d = S_R_W;
			S_R_W:   if (!stat.iter_busy) state_d = S_RS_S;
			S_RS_S:  state_d = S_RS_W;
			S_RS_W:  if (!stat.iter_busy) state_d = S_PUSH;
			S_PUSH:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q.step  <= hre_pkg::STEP_IDLE;
			cmd_q.ready <= 1'b1;
		end else begin
			state_q     <= state_d;
			cmd_q.step  <= hre_pkg::step_t'(state_d);
			cmd_q.ready <= (state_d == S_IDLE);
		end
	end

	assign cmd = cmd_q;

endmodule

// ----- design/homography_reprojection_error.sv -----
// Top level of the homography reprojection error block: ports, config registers, output word.
//
//  channel | signals                                   | direction | word
//  --------+-------------------------------------------+-----------+-----------------------------
//  s_      | s_tvalid s_tready s_tdata s_tlast         | in        | one point correspondence
//  m_      | m_tvalid m_tready m_tdata m_tuser m_tlast | out       | mapped point, error, status
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data    | in        | one register write
//
// Each item's work is paced by the shared divide/root unit: two 32-step roots for the
// tolerance, two 33+FRAC_BITS step divisions and one 32-step distance root. A last item adds
// a 64-step mean division and a 32-step root; an item whose denominator is too small skips
// the divisions and the distance root. A new item is taken only once the last is through.
// Reset clears the controller, the set accumulation and the config registers at once.
// The next word is accepted while the previous result waits in the output register; a result
// holds in the controller while the output register stays full.
module homography_reprojection_error #(
	parameter int FRAC_BITS  = hre_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = hre_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [127:0]                  s_tdata,   // src_x, src_y, dst_x, dst_y
	input  logic                          s_tlast,   // set_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [127:0]                  m_tdata,   // mapped_x, mapped_y, error_dist, rms_error
	output logic [2:0]                    m_tuser,   // point_status[1:0], rms_valid
	output logic                          m_tlast,   // set_end
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	logic [63:0] pair0_q, pair1_q, pair2_q, pair3_q;
	logic [31:0] hlast_q, tol_q;

	hre_pkg::coef_t coef;
	hre_pkg::cmd_t  cmd;
	hre_pkg::stat_t stat;
	hre_pkg::res_t  res;

	logic         in_take, out_free, push;
	logic         m_tvalid_q;
	logic [127:0] m_tdata_q;
	logic [2:0]   m_tuser_q;
	logic         m_tlast_q;

	// config writes are always taken; indexes past the list drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair0_q <= '0;
			pair1_q <= '0;
			pair2_q <= '0;
			pair3_q <= '0;
			hlast_q <= '0;
			tol_q   <= hre_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hre_pkg::REG_PAIR0: pair0_q <= cfg_data;
				hre_pkg::REG_PAIR1: pair1_q <= cfg_data;
				hre_pkg::REG_PAIR2: pair2_q <= cfg_data;
				hre_pkg::REG_PAIR3: pair3_q <= cfg_data;
				hre_pkg::REG_LAST:  hlast_q <= cfg_data[31:0];
				hre_pkg::REG_TOL:   tol_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign coef = '{h00: pair0_q[63:32], h01: pair0_q[31:0],
		h02: pair1_q[63:32], h10: pair1_q[31:0],
		h11: pair2_q[63:32], h12: pair2_q[31:0],
		h20: pair3_q[63:32], h21: pair3_q[31:0],
		h22: hlast_q, tol: tol_q};

	assign s_tready = cmd.ready;
	assign in_take  = s_tvalid && s_tready;
	// output register is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;
	assign push     = (cmd.step == hre_pkg::STEP_PUSH) && out_free;

	hre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd)
	);

	hre_dp #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.src_x    (s_tdata[31:0]),
		.src_y    (s_tdata[63:32]),
		.dst_x    (s_tdata[95:64]),
		.dst_y    (s_tdata[127:96]),
		.set_last (s_tlast),
		.coef     (coef),
		.cmd      (cmd),
		.stat     (stat),
		.res      (res)
	);

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_tdata_q <= {res.rms_error, res.error_dist, res.mapped_y, res.mapped_x};
			m_tuser_q <= {res.rms_valid, res.point_status};
			m_tlast_q <= res.set_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- test/tb_homography_reprojection_error.sv -----
// Testbench for the homography reprojection error block: random and directed correspondences.
`timescale 1ns / 100ps

module tb_homography_reprojection_error;

	// one expected output word
	typedef struct {
		logic [31:0] mx;
		logic [31:0] my;
		logic [31:0] err_len;
		logic [1:0]  status;
		logic [31:0] rms;
		logic        rms_ok;
		logic        set_end;
	} reproj_word_t;

	// Projection predictor: holds its own copy of the coefficients and the set state,
	// computes the expected word for every accepted correspondence and checks results.
	class reproj_scoreboard;
		logic [31:0] h[9];
		logic [31:0] tol;
		logic [63:0] sq_sum;
		longint unsigned n_items;
		bit failed;
		reproj_word_t pending[$];
		int mismatches;

		function void clear();
			foreach (h[i]) h[i] = '0;
			tol = hre_pkg::TOL_RESET;
			sq_sum = '0;
			n_items = 0;
			failed = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [hre_pkg::CFG_IDX_W-1:0] idx, logic [63:0] d);
			case (idx)
				hre_pkg::REG_PAIR0: begin h[0] = d[63:32]; h[1] = d[31:0]; end
				hre_pkg::REG_PAIR1: begin h[2] = d[63:32]; h[3] = d[31:0]; end
				hre_pkg::REG_PAIR2: begin h[4] = d[63:32]; h[5] = d[31:0]; end
				hre_pkg::REG_PAIR3: begin h[6] = d[63:32]; h[7] = d[31:0]; end
				hre_pkg::REG_LAST:  h[8] = d[31:0];
				hre_pkg::REG_TOL:   tol = d[31:0];
				default: ;
			endcase
		endfunction

		static function logic [63:0] root_floor(logic [63:0] v);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		static function logic [63:0] root_round(logic [63:0] v);
			logic [63:0] r;
			r = root_floor(v);
			if (v - r * r > r) r++;
			return r;
		endfunction

		// product of Q1.30 coefficient and coordinate, scaled down by 4 with floor
		static function longint scaled(logic [31:0] c, longint v);
			longint p;
			p = longint'($signed(c)) * v;
			return p >>> 2;
		endfunction

		static function logic [63:0] mag(longint v);
			return v < 0 ? 64'd0 - 64'(v) : 64'(v);
		endfunction

		static function longint quotient(longint n, longint d, ref bit sat);
			logic [63:0] un, ud, q, r, lim;
			bit neg;
			un = mag(n);
			ud = mag(d);
			neg = (n < 0) != (d < 0);
			q = un / ud;
			r = un % ud;
			lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			if (q >= 64'h1_0000_0000)
				q = lim + 1;
			else begin
				for (int i = 0; i <= 16; i++) begin
					r <<= 1;
					q <<= 1;
					if (r >= ud) begin
						r -= ud;
						q |= 1;
					end
				end
				q = (q + 1) >> 1;
			end
			if (q > lim) begin
				sat = 1;
				q = lim;
			end
			return neg ? -longint'(q) : longint'(q);
		endfunction

		function void note_input(logic [127:0] d, logic lst);
			longint x, y, dx, dy, one, bx, by, bw, mx, my;
			logic [63:0] ra, rp, m, lo, hi, thr, err_len, sq, ax, ay, ex, ey;
			bit sat;
			reproj_word_t w;
			x = longint'($signed(d[31:0]));
			y = longint'($signed(d[63:32]));
			dx = longint'($signed(d[95:64]));
			dy = longint'($signed(d[127:96]));
			one = 64'd1 << 16;
			mx = 0; my = 0; err_len = 0; sq = 0; sat = 0;
			bx = scaled(h[0], x) + scaled(h[1], y) + scaled(h[2], one);
			by = scaled(h[3], x) + scaled(h[4], y) + scaled(h[5], one);
			bw = scaled(h[6], x) + scaled(h[7], y) + scaled(h[8], one);
			ra = root_floor(64'(longint'($signed(h[6])) * longint'($signed(h[6])))
				+ 64'(longint'($signed(h[7])) * longint'($signed(h[7])))
				+ 64'(longint'($signed(h[8])) * longint'($signed(h[8]))));
			rp = root_floor(64'(x * x) + 64'(y * y) + 64'(one * one));
			m = ra * rp;
			lo = 64'(tol) * m[31:0];
			hi = 64'(tol) * m[63:32];
			thr = (hi + (lo >> 32)) >> 34;
			w.status = hre_pkg::PT_OK;
			if (mag(bw) <= thr)
				w.status = hre_pkg::PT_SMALL;
			else begin
				mx = quotient(bx, bw, sat);
				my = quotient(by, bw, sat);
				ax = mag(mx - dx);
				ay = mag(my - dy);
				ex = ax * ax;
				ey = ay * ay;
				sq = ex + ey;
				if (sq < ex) begin
					sq = '1;
					err_len = 64'hFFFF_FFFF;
					sat = 1;
				end else begin
					err_len = root_round(sq);
					if (err_len > 64'hFFFF_FFFF) begin
						err_len = 64'hFFFF_FFFF;
						sat = 1;
					end
				end
				if (sat) w.status = hre_pkg::PT_SAT;
				sq_sum = (sq_sum + sq < sq_sum) ? '1 : sq_sum + sq;
			end
			if (w.status != hre_pkg::PT_OK) failed = 1;
			if (n_items < 65535) n_items++;
			w.mx = mx[31:0];
			w.my = my[31:0];
			w.err_len = err_len[31:0];
			w.rms = 0;
			w.rms_ok = 0;
			w.set_end = lst;
			if (lst) begin
				m = root_round(sq_sum / n_items);
				w.rms = m > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : m[31:0];
				w.rms_ok = !failed;
				sq_sum = 0;
				n_items = 0;
				failed = 0;
			end
			pending = {pending, w};
		endfunction

		function void check_result(logic [127:0] d, logic [2:0] u, logic lst);
			reproj_word_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output word %h", d);
				return;
			end
			e = pending.pop_front();
			if (d[31:0] !== e.mx || d[63:32] !== e.my || d[95:64] !== e.err_len
					|| u[1:0] !== e.status || d[127:96] !== e.rms || u[2] !== e.rms_ok
					|| lst !== e.set_end) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp x=%h y=%h d=%h st=%0d rms=%h ok=%b end=%b",
						e.mx, e.my, e.err_len, e.status, e.rms, e.rms_ok, e.set_end);
					$display("          got x=%h y=%h d=%h st=%0d rms=%h ok=%b end=%b",
						d[31:0], d[63:32], d[95:64], u[1:0], d[127:96], u[2], lst);
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [127:0] s_tdata;
	logic m_tvalid, m_tready, m_tlast;
	logic [127:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_valid, cfg_ready;
	logic [hre_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	reproj_scoreboard board;

	homography_reprojection_error dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// hard limit: room for ~1500 items with worst stalls, several times over
	initial begin
		#(64'd40_000_000);
		$display("tb_homography_reprojection_error NOT OK");
		$finish;
	end

	// receiver: random stall (possibly none) before every word, checked on the handshake
	initial begin
		int hold;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			if (hold != 0) begin
				m_tready <= 0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			board.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	task automatic reg_write(logic [hre_pkg::CFG_IDX_W-1:0] idx, logic [63:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, d);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// wait until every expected word has arrived, then idle
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic send_point(logic [31:0] sx, sy, ddx, ddy, logic lst, bit gaps);
		if (gaps) repeat ($urandom_range(0, 5)) @(posedge clk);
		s_tvalid <= 1;
		s_tdata <= {ddy, ddx, sy, sx};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		board.note_input({ddy, ddx, sy, sx}, lst);
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	// random perturbation plus identity (q30 is 1.0) for kind 0; 1 random; 2 extremes; else last row 0
	task automatic load_matrix(int kind);
		logic [31:0] c[9];
		for (int i = 0; i < 9; i++) c[i] = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
		case (kind)
			0: begin c[0] += 32'h4000_0000; c[4] += 32'h4000_0000; c[8] += 32'h4000_0000; end
			1: for (int i = 0; i < 9; i++) c[i] = $urandom;
			2: begin
				for (int i = 0; i < 9; i++) c[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
			default: begin c[6] = 0; c[7] = 0; c[8] = 0; end
		endcase
		reg_write(hre_pkg::REG_PAIR0, {c[0], c[1]});
		reg_write(hre_pkg::REG_PAIR1, {c[2], c[3]});
		reg_write(hre_pkg::REG_PAIR2, {c[4], c[5]});
		reg_write(hre_pkg::REG_PAIR3, {c[6], c[7]});
		reg_write(hre_pkg::REG_LAST, {$urandom, c[8]});
	endtask

	function automatic logic [31:0] coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
		endcase
	endfunction

	initial begin
		logic [31:0] ex[8];
		board = new();
		board.clear();
		s_tvalid = 0; s_tdata = 0; s_tlast = 0;
		cfg_valid = 0; cfg_index = hre_pkg::REG_PAIR0; cfg_data = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset matrix is all zero: every point has a too-small denominator
		send_point(0, 0, 0, 0, 1, 0);
		drain();
		load_matrix(0);
		ex = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000,
			32'hFFFF_0000, 32'h1234_5678};
		// directed extremes in three-item sets
		for (int i = 0; i < 8; i++)
			send_point(ex[i], ex[(i + 3) % 8], ex[(i + 5) % 8], ex[7 - i], i % 3 == 2, 1);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 1);
		drain();
		reg_write(hre_pkg::REG_TOL, 64'h0000_0000_FFFF_FFFF);
		send_point(32'h0001_0000, 0, 0, 0, 1, 0);
		drain();
		reg_write(hre_pkg::REG_TOL, 64'd0);
		load_matrix(2);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
		send_point(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0);
		drain();
		load_matrix(3);
		send_point(32'h0003_0000, 32'hFFFE_0000, 0, 0, 1, 0);
		drain();

		// random phases: mostly sane matrices, sets of random length
		for (int ph = 0; ph < 12; ph++) begin
			load_matrix(ph % 6 == 5 ? 1 : (ph == 7 ? 2 : 0));
			reg_write(hre_pkg::REG_TOL, 64'(ph % 4 == 0 ? hre_pkg::TOL_RESET
				: (ph % 4 == 1 ? 32'h0 : (ph % 4 == 2 ? 32'hFFFF_FFFF : $urandom))));
			for (int k = 0; k < 95; k++) begin
				logic [31:0] sx, sy;
				sx = coord();
				sy = coord();
				send_point(sx, sy, $urandom_range(0, 3) == 0 ? coord() : sx + $urandom_range(0, 4000)
					- 2000, $urandom_range(0, 3) == 0 ? coord() : sy + $urandom_range(0, 4000)
					- 2000, $urandom_range(0, 7) == 0 || k == 94, ph % 3 != 0);
				// hold the sender until the block has emptied, once per phase
				if (k == 40) while (board.pending.size() != 0) @(posedge clk);
			end
			drain();
		end
		repeat (50) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_homography_reprojection_error OK");
		else
			$display("tb_homography_reprojection_error NOT OK");
		$finish;
	end

endmodule
